@@ hw/rtl/ffha_pkg.sv @@
// Package with the shared types and constants of the first-fit heap allocator.
`timescale 1ns / 1ps

package ffha_pkg;

   // Header fields: payload size and free mark.
   localparam int SIZE_W = 13;
   localparam logic [SIZE_W-1:0] SIZE_LIMIT = 13'd8191;

   // Defaults of the top-level parameters.
   localparam int POOL_MAX_BYTES_DEF = 4096;
   localparam int HEADER_BYTES_DEF = 16;

   // Pool size loaded by reset.
   localparam int POOL_RESET_BYTES = 4096;

   // Register index decoded from the address (one register).
   localparam logic REG_POOL_BYTES = 1'b0;

   typedef struct packed {
      logic              free;
      logic [SIZE_W-1:0] size;
   } hdr_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FIT    = 2'd1,
      ST_BAD_REQ   = 2'd2,
      ST_TOO_SMALL = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_ALLOC_RD,
      FSM_ALLOC_CHK,
      FSM_ALLOC_WR,
      FSM_FREE_RD,
      FSM_FREE_CHK,
      FSM_MERGE_CHK,
      FSM_WALK_RD,
      FSM_WALK_CHK,
      FSM_DONE
   } fsm_type;

endpackage

@@ hw/rtl/first_fit_heap_allocator_top.sv @@
// First-fit heap allocator: header store, walk sequencer and the request ports.
`timescale 1ns / 1ps

// The block keeps a byte pool as a chain of blocks, each led by a header with a payload
// size and a free mark, held in one synchronous memory (header at offset 0 in flip-flops).
// One request is worked on at a time. An allocate walks the chain from offset 0; each
// header visited is read from the store, then checked; a split writes the remainder
// header, then the granted one, and the response is posted last. A free reads and marks
// the block, checks the successor for a merge, then walks from offset 0 to the predecessor.
// Requests that are refused up front (zero size, null or out-of-pool free, pool too
// small) skip the walk and go straight to the response. A finished response waits in an
// output register while the next request is taken. Writing pool_bytes re-initializes the
// pool to one free block (none if shorter than a header) by rewriting the first header;
// no clearing pass is needed.
module first_fit_heap_allocator_top #(
   parameter int POOL_MAX_BYTES = ffha_pkg::POOL_MAX_BYTES_DEF,
   parameter int HEADER_BYTES   = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [12:0] req_request_bytes,
   input  logic [11:0] req_release_offset,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_payload_offset,
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(POOL_MAX_BYTES);
   localparam int SW = ffha_pkg::SIZE_W;
   localparam int WW = ((AW > SW) ? AW : SW) + 2;
   localparam int RESET_LEN = (ffha_pkg::POOL_RESET_BYTES > POOL_MAX_BYTES) ?
                              POOL_MAX_BYTES : ffha_pkg::POOL_RESET_BYTES;
   localparam logic [WW-1:0] HB_W    = WW'(HEADER_BYTES);
   localparam logic [WW-1:0] PMAX_W  = WW'(POOL_MAX_BYTES);
   localparam logic [WW-1:0] LIMIT_W = WW'(ffha_pkg::SIZE_LIMIT);

   // Header store (offset 0 lives in hdr0_ff).
   ffha_pkg::hdr_type mem [POOL_MAX_BYTES];
   ffha_pkg::hdr_type mem_q_ff;
   logic              rd_zero_ff;
   ffha_pkg::hdr_type hdr0_ff, hdr0_in;

   // Control and payload registers.
   ffha_pkg::fsm_type    state_ff, state_in;
   logic [SW-1:0]        pool_bytes_ff, pool_bytes_in;
   logic [AW-1:0]        cur_ff, cur_in;
   logic [AW-1:0]        blk_ff, blk_in;
   logic [SW-1:0]        bsz_ff, bsz_in;
   logic [SW-1:0]        want_ff, want_in;
   ffha_pkg::opcode_type op_ff, op_in;
   ffha_pkg::status_type res_status_ff, res_status_in;
   logic [11:0]          res_off_ff, res_off_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ffha_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [11:0]          rsp_off_ff, rsp_off_in;

   // Datapath signals.
   ffha_pkg::hdr_type hdr_rd;
   logic [WW-1:0]     pool_len_w, new_len_w;
   logic [WW-1:0]     base_w, hsz_w, next_w, want_w, rel_w, blk_w, cur_w;
   logic              has_next;
   logic [WW-1:0]     merge_w;
   logic [SW-1:0]     merge_sz;
   logic              rd_en;
   logic [WW-1:0]     rd_addr;
   logic              wr_en, mem_we;
   logic [WW-1:0]     wr_addr;
   ffha_pkg::hdr_type wr_hdr;
   logic              cfg_we, req_fire, slot_free;

   // Handshake and configuration decode.
   assign req_ready  = (state_ff == ffha_pkg::FSM_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == ffha_pkg::REG_POOL_BYTES);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ffha_pkg::REG_POOL_BYTES) ?
                       {{(32 - SW){1'b0}}, pool_bytes_ff} : 32'd0;
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // Pool length saturates at the store depth.
   assign pool_len_w = (WW'(pool_bytes_ff) > PMAX_W) ? PMAX_W : WW'(pool_bytes_ff);
   assign new_len_w  = (WW'(csr_pwdata[SW-1:0]) > PMAX_W) ? PMAX_W
                                                           : WW'(csr_pwdata[SW-1:0]);

   // Header read back from the store, and the successor position of the current block.
   assign hdr_rd   = rd_zero_ff ? hdr0_ff : mem_q_ff;
   assign base_w   = (state_ff == ffha_pkg::FSM_FREE_CHK) ? WW'(blk_ff) : WW'(cur_ff);
   assign cur_w    = WW'(cur_ff);
   assign hsz_w    = WW'(hdr_rd.size);
   assign next_w   = base_w + HB_W + hsz_w;
   assign has_next = (next_w + HB_W) <= pool_len_w;
   assign want_w   = WW'(want_ff);
   assign rel_w    = WW'(req_release_offset);
   assign blk_w    = rel_w - HB_W;

   // Merged size: the read header plus the block being freed, saturated.
   assign merge_w  = hsz_w + WW'(bsz_ff) + HB_W;
   assign merge_sz = (merge_w > LIMIT_W) ? ffha_pkg::SIZE_LIMIT : merge_w[SW-1:0];

   // Sequencer: next state, store accesses and result.
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      blk_in        = blk_ff;
      bsz_in        = bsz_ff;
      want_in       = want_ff;
      op_in         = op_ff;
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_hdr        = '0;
      unique case (state_ff)
         ffha_pkg::FSM_IDLE: begin
            if (req_fire) begin
               op_in         = ffha_pkg::opcode_type'(req_opcode);
               want_in       = req_request_bytes;
               res_status_in = ffha_pkg::ST_OK;
               res_off_in    = '0;
               cur_in        = '0;
               blk_in        = AW'(blk_w);
               priority if (pool_len_w < HB_W) begin
                  res_status_in = ffha_pkg::ST_TOO_SMALL;
                  state_in      = ffha_pkg::FSM_DONE;
               end else if (req_opcode == ffha_pkg::OP_ALLOC) begin
                  if (req_request_bytes == '0) begin
                     res_status_in = ffha_pkg::ST_BAD_REQ;
                     state_in      = ffha_pkg::FSM_DONE;
                  end else begin
                     state_in = ffha_pkg::FSM_ALLOC_RD;
                  end
               end else if (rel_w < HB_W || blk_w >= pool_len_w) begin
                  // Null, below-header and out-of-pool frees are ignored.
                  state_in = ffha_pkg::FSM_DONE;
               end else begin
                  state_in = ffha_pkg::FSM_FREE_RD;
               end
            end
         end
         ffha_pkg::FSM_ALLOC_RD: begin
            rd_en    = 1'b1;
            rd_addr  = cur_w;
            state_in = ffha_pkg::FSM_ALLOC_CHK;
         end
         ffha_pkg::FSM_ALLOC_CHK: begin
            if (hdr_rd.free && hdr_rd.size >= want_ff) begin
               res_off_in = 12'(cur_w + HB_W);
               wr_en      = 1'b1;
               if (hsz_w >= want_w + HB_W + WW'(1)) begin
                  // Split the remainder off as a new free block.
                  wr_addr     = cur_w + HB_W + want_w;
                  wr_hdr.free = 1'b1;
                  wr_hdr.size = SW'(hsz_w - want_w - HB_W);
                  state_in    = ffha_pkg::FSM_ALLOC_WR;
               end else begin
                  wr_addr     = cur_w;
                  wr_hdr.free = 1'b0;
                  wr_hdr.size = hdr_rd.size;
                  state_in    = ffha_pkg::FSM_DONE;
               end
            end else if (has_next) begin
               cur_in   = AW'(next_w);
               state_in = ffha_pkg::FSM_ALLOC_RD;
            end else begin
               res_status_in = ffha_pkg::ST_NO_FIT;
               state_in      = ffha_pkg::FSM_DONE;
            end
         end
         ffha_pkg::FSM_ALLOC_WR: begin
            wr_en       = 1'b1;
            wr_addr     = cur_w;
            wr_hdr.free = 1'b0;
            wr_hdr.size = want_ff;
            state_in    = ffha_pkg::FSM_DONE;
         end
         ffha_pkg::FSM_FREE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = WW'(blk_ff);
            state_in = ffha_pkg::FSM_FREE_CHK;
         end
         ffha_pkg::FSM_FREE_CHK: begin
            // Mark the block free and fetch its successor for a merge.
            wr_en       = 1'b1;
            wr_addr     = WW'(blk_ff);
            wr_hdr.free = 1'b1;
            wr_hdr.size = hdr_rd.size;
            bsz_in      = hdr_rd.size;
            cur_in      = '0;
            if (has_next) begin
               rd_en    = 1'b1;
               rd_addr  = next_w;
               state_in = ffha_pkg::FSM_MERGE_CHK;
            end else begin
               state_in = ffha_pkg::FSM_WALK_RD;
            end
         end
         ffha_pkg::FSM_MERGE_CHK: begin
            if (hdr_rd.free) begin
               wr_en       = 1'b1;
               wr_addr     = WW'(blk_ff);
               wr_hdr.free = 1'b1;
               wr_hdr.size = merge_sz;
               bsz_in      = merge_sz;
            end
            state_in = ffha_pkg::FSM_WALK_RD;
         end
         ffha_pkg::FSM_WALK_RD: begin
            rd_en    = 1'b1;
            rd_addr  = cur_w;
            state_in = ffha_pkg::FSM_WALK_CHK;
         end
         ffha_pkg::FSM_WALK_CHK: begin
            if (has_next && next_w == WW'(blk_ff)) begin
               // Predecessor found: absorb the freed block if it is free too.
               if (hdr_rd.free) begin
                  wr_en       = 1'b1;
                  wr_addr     = cur_w;
                  wr_hdr.free = 1'b1;
                  wr_hdr.size = merge_sz;
               end
               state_in = ffha_pkg::FSM_DONE;
            end else if (!has_next) begin
               state_in = ffha_pkg::FSM_DONE;
            end else begin
               cur_in   = AW'(next_w);
               state_in = ffha_pkg::FSM_WALK_RD;
            end
         end
         ffha_pkg::FSM_DONE: begin
            if (slot_free) begin
               state_in = ffha_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = ffha_pkg::FSM_IDLE;
         end
      endcase
   end

   // Header writes go to the offset-zero register or to the store.
   assign mem_we = wr_en && (wr_addr != '0) && (wr_addr < PMAX_W);

   always_comb begin
      pool_bytes_in = pool_bytes_ff;
      hdr0_in       = hdr0_ff;
      if (cfg_we) begin
         pool_bytes_in = csr_pwdata[SW-1:0];
         hdr0_in       = '0;
         if (new_len_w >= HB_W) begin
            hdr0_in.free = 1'b1;
            hdr0_in.size = SW'(new_len_w - HB_W);
         end
      end else if (wr_en && wr_addr == '0) begin
         hdr0_in = wr_hdr;
      end
   end

   // Response register: loaded from the result when the slot is free.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      if (state_ff == ffha_pkg::FSM_DONE && slot_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_off_in    = res_off_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_off_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ffha_pkg::FSM_IDLE;
         rsp_valid_ff  <= 1'b0;
         pool_bytes_ff <= SW'(ffha_pkg::POOL_RESET_BYTES);
         hdr0_ff.free  <= (RESET_LEN >= HEADER_BYTES);
         hdr0_ff.size  <= (RESET_LEN >= HEADER_BYTES) ? SW'(RESET_LEN - HEADER_BYTES) : '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pool_bytes_ff <= pool_bytes_in;
         hdr0_ff       <= hdr0_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      blk_ff        <= blk_in;
      bsz_ff        <= bsz_in;
      want_ff       <= want_in;
      op_ff         <= op_in;
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
   end

   // Header store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr[AW-1:0]] <= wr_hdr;
      end
      if (rd_en) begin
         mem_q_ff   <= mem[rd_addr[AW-1:0]];
         rd_zero_ff <= (rd_addr == '0);
      end
   end

`ifndef SYNTHESIS
   // A response other than ok never carries a granted offset.
   a_no_offset_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ffha_pkg::ST_OK || rsp_payload_offset == '0))
      else $error("error response carries a payload offset");

   // A free only ever answers ok or pool too small.
   a_free_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffha_pkg::FSM_DONE && op_ff == ffha_pkg::OP_FREE) |->
      (res_status_ff == ffha_pkg::ST_OK || res_status_ff == ffha_pkg::ST_TOO_SMALL))
      else $error("free request produced an allocate status");

   // An accepted request always leaves idle.
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ffha_pkg::FSM_IDLE)
      else $error("accepted request did not start");

   // The store is never read and written at the same entry in one cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (rd_en && mem_we) |-> rd_addr != wr_addr)
      else $error("header store read and write collide");

   // A pool write re-creates the first header to match the new length.
   a_cfg_hdr0: assert property (@(posedge clock) disable iff (reset)
      cfg_we |=> hdr0_ff.free == (pool_len_w >= HB_W))
      else $error("first header does not match the pool length");
`endif

endmodule

@@ dv/first_fit_heap_allocator_checker.sv @@
// Checker that predicts and compares every response of the first-fit heap allocator.
`timescale 1ns / 1ps

module first_fit_heap_allocator_checker #(
   parameter int POOL_MAX = ffha_pkg::POOL_MAX_BYTES_DEF,
   parameter int HDR      = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_opcode,
   input  logic [12:0] req_request_bytes,
   input  logic [11:0] req_release_offset,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [11:0] rsp_payload_offset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      ffha_pkg::status_type status;
      logic [11:0]          offset;
   } outcome_type;

   // Shadow copy of the header store and of the pool size register.
   logic [ffha_pkg::SIZE_W-1:0] blk_size [POOL_MAX];
   bit                          blk_free [POOL_MAX];
   logic [12:0]                 pool_reg;

   // Outcomes of accepted requests, oldest first.
   outcome_type outcome_q[$];
   outcome_type due;

   function automatic int usable_bytes();
      return (int'(pool_reg) > POOL_MAX) ? POOL_MAX : int'(pool_reg);
   endfunction

   function automatic int size_at(int off);
      return (off < POOL_MAX) ? int'(blk_size[off]) : 0;
   endfunction

   function automatic bit free_at(int off);
      return (off < POOL_MAX) ? blk_free[off] : 1'b0;
   endfunction

   // Header writes outside the store are dropped; sizes saturate.
   function automatic void write_hdr(int off, int size, bit fr);
      if (off < POOL_MAX) begin
         blk_size[off] = (size > int'(ffha_pkg::SIZE_LIMIT)) ? ffha_pkg::SIZE_LIMIT
                                                             : ffha_pkg::SIZE_W'(size);
         blk_free[off] = fr;
      end
   endfunction

   function automatic int next_hdr(int off);
      return off + HDR + size_at(off);
   endfunction

   function automatic bit has_next_hdr(int off);
      return next_hdr(off) + HDR <= usable_bytes();
   endfunction

   function automatic void format_pool();
      for (int i = 0; i < POOL_MAX; i++) begin
         blk_size[i] = '0;
         blk_free[i] = 1'b0;
      end
      if (usable_bytes() >= HDR) begin
         write_hdr(0, usable_bytes() - HDR, 1'b1);
      end
   endfunction

   // First-fit walk from offset 0, splitting when the remainder holds a header and a byte.
   function automatic outcome_type take_block(int want);
      int          cur;
      int          sz;
      outcome_type res;
      cur = 0;
      res.status = ffha_pkg::ST_OK;
      res.offset = '0;
      if (want == 0) begin
         res.status = ffha_pkg::ST_BAD_REQ;
         return res;
      end
      while (1) begin
         sz = size_at(cur);
         if (free_at(cur) && sz >= want) begin
            if (sz >= want + HDR + 1) begin
               write_hdr(cur + HDR + want, sz - want - HDR, 1'b1);
               sz = want;
            end
            write_hdr(cur, sz, 1'b0);
            res.offset = 12'(cur + HDR);
            return res;
         end
         if (!has_next_hdr(cur)) begin
            res.status = ffha_pkg::ST_NO_FIT;
            return res;
         end
         cur = next_hdr(cur);
      end
      return res;
   endfunction

   // Mark free, merge with a free successor, then with a free predecessor.
   function automatic void release_block(int p);
      int blk;
      int cur;
      int nx;
      if (p == 0 || p < HDR) begin
         return;
      end
      blk = p - HDR;
      if (blk >= usable_bytes()) begin
         return;
      end
      write_hdr(blk, size_at(blk), 1'b1);
      if (has_next_hdr(blk)) begin
         nx = next_hdr(blk);
         if (free_at(nx)) begin
            write_hdr(blk, size_at(blk) + size_at(nx) + HDR, 1'b1);
         end
      end
      cur = 0;
      while (1) begin
         if (has_next_hdr(cur) && next_hdr(cur) == blk) begin
            break;
         end
         if (!has_next_hdr(cur)) begin
            return;
         end
         cur = next_hdr(cur);
      end
      if (free_at(cur)) begin
         write_hdr(cur, size_at(cur) + size_at(blk) + HDR, 1'b1);
      end
   endfunction

   function automatic outcome_type heap_outcome(ffha_pkg::opcode_type op, int want, int rel);
      outcome_type res;
      res.status = ffha_pkg::ST_OK;
      res.offset = '0;
      if (usable_bytes() < HDR) begin
         res.status = ffha_pkg::ST_TOO_SMALL;
      end else if (op == ffha_pkg::OP_ALLOC) begin
         res = take_block(want);
      end else begin
         release_block(rel);
      end
      return res;
   endfunction

   task automatic report(string msg);
      if (fail_count < 10) begin
         $display("%0t: %s", $realtime, msg);
      end
      fail_count++;
   endtask

   // Responses are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         pool_reg = 13'(ffha_pkg::POOL_RESET_BYTES);
         format_pool();
         outcome_q.delete();
         fail_count = 0;
         pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               report($sformatf("response with no request outstanding: status %0d offset %0d",
                                rsp_status, rsp_payload_offset));
            end else begin
               due = outcome_q.pop_front();
               if (rsp_status !== due.status || rsp_payload_offset !== due.offset) begin
                  report($sformatf("expected status %0d offset %0d, got status %0d offset %0d",
                                   due.status, due.offset, rsp_status, rsp_payload_offset));
               end
            end
         end
         if (req_valid && req_ready) begin
            outcome_q.push_back(heap_outcome(ffha_pkg::opcode_type'(req_opcode),
                                             int'(req_request_bytes),
                                             int'(req_release_offset)));
         end
         // Register access: a write formats the pool, a read must return the value.
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[2] == ffha_pkg::REG_POOL_BYTES) begin
            if (csr_pwrite) begin
               pool_reg = csr_pwdata[12:0];
               format_pool();
            end else if (csr_prdata !== {19'd0, pool_reg}) begin
               report($sformatf("expected pool_bytes %0d, read %0d", pool_reg, csr_prdata));
            end
         end
         pending <= pending + int'(req_valid && req_ready) - int'(rsp_valid && rsp_ready);
      end
   end

endmodule

@@ dv/first_fit_heap_allocator_top_test.sv @@
// Testbench top: clock, reset, request stimulus, response stalls and the verdict.
`timescale 1ns / 1ps

module first_fit_heap_allocator_top_test;

   localparam int HDR        = ffha_pkg::HEADER_BYTES_DEF;
   localparam int POOL_MAX   = ffha_pkg::POOL_MAX_BYTES_DEF;
   localparam int STUCK_MAX  = 20000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [12:0] req_request_bytes;
   logic [11:0] req_release_offset;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_payload_offset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending;
   int stall_pct = 0;
   int idle_pct;
   int pool_len;
   int stuck;

   // Payload offsets granted since the last pool format.
   logic [11:0] live_offsets[$];
   logic [11:0] granted_offsets[$];

   first_fit_heap_allocator_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_request_bytes  (req_request_bytes),
      .req_release_offset (req_release_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_payload_offset (rsp_payload_offset),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   first_fit_heap_allocator_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_request_bytes  (req_request_bytes),
      .req_release_offset (req_release_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_payload_offset (rsp_payload_offset),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The response side stalls at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog on cycles in which nothing at all is accepted.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         stuck <= 0;
      end else if (stuck >= STUCK_MAX) begin
         $display("tb: failure");
         $finish;
      end else begin
         stuck <= stuck + 1;
      end
   end

   // One clock edge; grants seen at this edge become candidates for later frees.
   task automatic tick();
      @(posedge clock);
      if (rsp_valid && rsp_ready && rsp_status == ffha_pkg::ST_OK &&
          rsp_payload_offset != '0) begin
         live_offsets.push_back(rsp_payload_offset);
         granted_offsets.push_back(rsp_payload_offset);
      end
   endtask

   task automatic send_request(ffha_pkg::opcode_type op, logic [12:0] nbytes,
                               logic [11:0] rel);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         tick();
      end
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_request_bytes  <= nbytes;
      req_release_offset <= rel;
      do tick(); while (!(req_valid && req_ready));
   endtask

   // Hold the request side until every outstanding response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do tick(); while (pending != 0);
   endtask

   task automatic csr_access(logic wr, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {ffha_pkg::REG_POOL_BYTES, 2'b00};
      csr_pwdata  <= data;
      tick();
      csr_penable <= 1'b1;
      do tick(); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      tick();
   endtask

   // Reformat the pool with a new size and read it back.
   task automatic set_pool(int value);
      drain();
      csr_access(1'b1, 32'(value));
      csr_access(1'b0, 32'd0);
      pool_len = (value > POOL_MAX) ? POOL_MAX : value;
      live_offsets.delete();
      granted_offsets.delete();
      granted_offsets.push_back(12'(HDR));
   endtask

   // One random request, mostly allocate and release pairs on the current pool.
   task automatic random_request();
      int          pick;
      int          idx;
      logic [12:0] nbytes;
      logic [11:0] rel;
      pick   = $urandom_range(99);
      nbytes = 13'($urandom_range(8191, 0));
      rel    = 12'($urandom_range(4095, 0));
      if (pool_len < HDR) begin
         send_request(ffha_pkg::opcode_type'($urandom_range(1, 0)), nbytes, rel);
      end else if (pick < 50) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            nbytes = 13'($urandom_range(48, 1));
         end else if (pick < 88) begin
            nbytes = 13'($urandom_range(pool_len / 3 + 1, 1));
         end else if (pick < 97) begin
            nbytes = (pick < 94) ? nbytes : 13'(pool_len - HDR);
         end else begin
            nbytes = '0;
         end
         send_request(ffha_pkg::OP_ALLOC, nbytes, rel);
      end else begin
         // Frees mostly name granted offsets; others are edge or out-of-pool pointers.
         pick = $urandom_range(99);
         if (pick < 72 && live_offsets.size() > 0) begin
            idx = $urandom_range(live_offsets.size() - 1, 0);
            rel = live_offsets[idx];
            live_offsets.delete(idx);
         end else if (pick < 82 && granted_offsets.size() > 0) begin
            rel = granted_offsets[$urandom_range(granted_offsets.size() - 1, 0)];
         end else if (pick < 86) begin
            rel = 12'(HDR);
         end else if (pick < 92) begin
            rel = 12'($urandom_range(HDR - 1, 0));
         end else if (pool_len + HDR <= 4095) begin
            rel = 12'($urandom_range(4095, pool_len + HDR));
         end else begin
            rel = 12'(HDR);
         end
         send_request(ffha_pkg::OP_FREE, nbytes, rel);
      end
   endtask

   task automatic run_phase(int value, int count, int idle, int stall);
      set_pool(value);
      idle_pct = idle;
      stall_pct <= stall;
      for (int n = 0; n < count; n++) begin
         random_request();
         if (n % 64 == 63) begin
            drain();
         end
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_opcode         <= ffha_pkg::OP_ALLOC;
      req_request_bytes  <= '0;
      req_release_offset <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      idle_pct = 0;
      pool_len = POOL_MAX;
      repeat (4) tick();
      reset <= 1'b0;
      tick();

      // Directed: zero size, oversize, exact fit, split and no split, and every
      // merge direction on the pool left by reset.
      send_request(ffha_pkg::OP_ALLOC, 13'd0, 12'd0);
      send_request(ffha_pkg::OP_ALLOC, 13'd8191, 12'd4095);
      send_request(ffha_pkg::OP_ALLOC, 13'd4080, 12'd0);
      send_request(ffha_pkg::OP_ALLOC, 13'd1, 12'd0);
      send_request(ffha_pkg::OP_FREE, 13'd0, 12'd16);
      send_request(ffha_pkg::OP_ALLOC, 13'd4064, 12'd0);
      send_request(ffha_pkg::OP_FREE, 13'd0, 12'd16);
      send_request(ffha_pkg::OP_ALLOC, 13'd4063, 12'd0);
      send_request(ffha_pkg::OP_FREE, 13'd0, 12'd16);
      send_request(ffha_pkg::OP_ALLOC, 13'd1, 12'd0);
      send_request(ffha_pkg::OP_ALLOC, 13'd1, 12'd0);
      send_request(ffha_pkg::OP_ALLOC, 13'd2, 12'd0);
      send_request(ffha_pkg::OP_FREE, 13'd0, 12'd33);
      send_request(ffha_pkg::OP_FREE, 13'd0, 12'd16);
      send_request(ffha_pkg::OP_FREE, 13'd0, 12'd50);
      // Null pointer, pointer inside the first header, and a repeated free.
      send_request(ffha_pkg::OP_FREE, 13'd0, 12'd0);
      send_request(ffha_pkg::OP_FREE, 13'd0, 12'd15);
      send_request(ffha_pkg::OP_FREE, 13'd0, 12'd16);
      // Pool too small for a header: every request is refused.
      set_pool(0);
      send_request(ffha_pkg::OP_ALLOC, 13'd5, 12'd0);
      send_request(ffha_pkg::OP_FREE, 13'd0, 12'd16);
      // Pool of a bare header, and frees beyond the pool.
      set_pool(16);
      send_request(ffha_pkg::OP_ALLOC, 13'd1, 12'd0);
      send_request(ffha_pkg::OP_FREE, 13'd0, 12'd32);
      send_request(ffha_pkg::OP_FREE, 13'd0, 12'd4095);
      set_pool(17);
      send_request(ffha_pkg::OP_ALLOC, 13'd1, 12'd0);
      // A size above the maximum saturates to the full pool.
      set_pool(8191);
      send_request(ffha_pkg::OP_ALLOC, 13'd4080, 12'd0);

      // Random phases over several pool sizes and handshake pressures.
      run_phase(4096, 200, 0, 0);
      run_phase(8191, 150, 48, 0);
      run_phase($urandom_range(4096, 200), 150, 0, 48);
      run_phase(64, 120, 25, 25);
      run_phase(15, 60, 48, 48);
      run_phase(1000, 150, 25, 25);
      run_phase(16, 40, 0, 0);
      run_phase(17, 40, 48, 0);
      run_phase(4096, 250, 25, 25);
      run_phase($urandom_range(4096, 17), 150, 0, 48);
      run_phase(5000, 150, 0, 0);

      drain();
      repeat (16) tick();
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
